>>> rtl/core/rpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types and codes for the ray / primitive intersection unit.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_LAT   = 3;

  localparam logic [1:0] MODE_PLANE  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_CYL    = 2'd2;
  localparam logic [1:0] MODE_CONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

  typedef struct packed {
    logic        [1:0]         mode;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] obj_pos_x;
    logic signed [COORD_W-1:0] obj_pos_y;
    logic signed [COORD_W-1:0] obj_pos_z;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
    logic        [COORD_W-2:0] radius;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] distance;
  } rsp_t;

endpackage

>>> rtl/core/rpi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_mul
// Signed multiplier, three stages: magnitude, four half-width partial
// products, recombine and restore sign.
// ----------------------------------------------------------------------------
module rpi_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AW-1:0]    am;
  logic [BW-1:0]    bm;
  logic             sg1, sg2;
  logic [AL+BL-1:0] pp_ll;
  logic [AL+BH-1:0] pp_lh;
  logic [AH+BL-1:0] pp_hl;
  logic [AH+BH-1:0] pp_hh;
  logic [PW-1:0]    sum;

  assign sum = PW'(pp_ll) + (PW'(pp_lh) << BL) + (PW'(pp_hl) << AL)
             + (PW'(pp_hh) << (AL + BL));

  always_ff @(posedge clk) begin
    if (en) begin
      am    <= a[AW-1] ? $unsigned(-a) : $unsigned(a);
      bm    <= b[BW-1] ? $unsigned(-b) : $unsigned(b);
      sg1   <= a[AW-1] ^ b[BW-1];
      pp_ll <= am[AL-1:0] * bm[BL-1:0];
      pp_lh <= am[AL-1:0] * bm[BW-1:BL];
      pp_hl <= am[AW-1:AL] * bm[BL-1:0];
      pp_hh <= am[AW-1:AL] * bm[BW-1:BL];
      sg2   <= sg1;
      p     <= $signed(sg2 ? -sum : sum);
    end
  end

endmodule

>>> rtl/core/ray_primitive_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_primitive_intersection
// Ray against plane, sphere, y-axis cylinder or y-axis cone, Q16.16 in/out.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle while req_stall is low.
// The pipeline runs through the square-root chain, one root bit per stage,
// followed by the divider, one quotient bit per stage. A stalled output parks
// one result in a skid register and the whole pipeline holds until it drains.
// The user must write the ray origin through the configuration port only
// while no item is in flight; the block itself does not enforce it.
module ray_primitive_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  rpi_pkg::req_t                       req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output rpi_pkg::rsp_t                       rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [rpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic signed [rpi_pkg::COORD_W-1:0]  cfg_data
);

  import rpi_pkg::*;

  localparam int W    = COORD_W;
  localparam int F    = FRAC_BITS;
  localparam int CW   = W + 1;
  localparam int PW   = 2 * CW;
  localparam int QW   = 2 * W + 4;
  localparam int HW   = 2 * QW;
  localparam int RW   = QW;
  localparam int NW   = QW + 2;
  localparam int MW   = NW - 1;
  localparam int XW   = MW + F + W;
  localparam int KW   = 14;
  localparam int TW   = HW + 4 * F + 2;
  localparam int NMUL = 10;

  localparam logic [TW-1:0] ONE4 = {{(TW-4*F-1){1'b0}}, 1'b1, {(4*F){1'b0}}};
  localparam logic [TW-1:0] HMIN = (ONE4 + TW'(9999)) / TW'(10000);
  localparam logic signed [W-1:0] DIST_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DIST_MIN = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic skid_v;
  rsp_t skid;

  assign en        = !skid_v;
  assign req_stall = skid_v;
  assign cfg_ready = 1'b1;

  // origin registers
  logic signed [W-1:0] origin_x, origin_y, origin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: capture, c = o - p
  logic                 v0;
  logic [1:0]           mode0;
  logic signed [W-1:0]  dx0, dy0, dz0, nx0, ny0, nz0;
  logic signed [CW-1:0] cx0, cy0, cz0;
  logic [W-2:0]         r0;
  logic                 pl0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0 <= req.mode;
      dx0   <= req.dir_x;
      dy0   <= req.dir_y;
      dz0   <= req.dir_z;
      nx0   <= req.normal_x;
      ny0   <= req.normal_y;
      nz0   <= req.normal_z;
      r0    <= req.radius;
      cx0   <= CW'(origin_x) - CW'(req.obj_pos_x);
      cy0   <= CW'(origin_y) - CW'(req.obj_pos_y);
      cz0   <= CW'(origin_z) - CW'(req.obj_pos_z);
    end
  end

  assign pl0 = (mode0 == MODE_PLANE);

  // first-level products
  logic signed [CW-1:0] ma [NMUL];
  logic signed [CW-1:0] mb [NMUL];
  logic signed [PW-1:0] mp [NMUL];

  always_comb begin
    ma[0] = pl0 ? CW'(nx0) : CW'(dx0);  mb[0] = CW'(dx0);
    ma[1] = pl0 ? CW'(ny0) : CW'(dy0);  mb[1] = CW'(dy0);
    ma[2] = pl0 ? CW'(nz0) : CW'(dz0);  mb[2] = CW'(dz0);
    ma[3] = pl0 ? CW'(nx0) : cx0;       mb[3] = pl0 ? cx0 : CW'(dx0);
    ma[4] = pl0 ? CW'(ny0) : cy0;       mb[4] = pl0 ? cy0 : CW'(dy0);
    ma[5] = pl0 ? CW'(nz0) : cz0;       mb[5] = pl0 ? cz0 : CW'(dz0);
    ma[6] = cx0;                        mb[6] = cx0;
    ma[7] = cy0;                        mb[7] = cy0;
    ma[8] = cz0;                        mb[8] = cz0;
    ma[9] = $signed({2'b00, r0});       mb[9] = $signed({2'b00, r0});
  end

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    rpi_mul #(.AW(CW), .BW(CW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma[i]),
      .b   (mb[i]),
      .p   (mp[i])
    );
  end

  logic [MUL_LAT-1:0] m1_v;
  logic [1:0]         m1_mode [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) m1_v <= '0;
    else if (en) m1_v <= {m1_v[MUL_LAT-2:0], v0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mode[0] <= mode0;
      for (int i = 1; i < MUL_LAT; i++) m1_mode[i] <= m1_mode[i-1];
    end
  end

  // stage 1: a, b, c (plane: den, -num)
  logic signed [QW-1:0] e [NMUL];
  logic signed [QW-1:0] ay, by, cy7, cz;
  logic                 v1, pl1;
  logic signed [QW-1:0] qa1, qb1, qc1;

  always_comb begin
    for (int i = 0; i < NMUL; i++) e[i] = QW'(mp[i]);
    case (m1_mode[MUL_LAT-1])
      MODE_PLANE, MODE_SPHERE: begin
        ay = e[1];  by = e[4];  cy7 = e[7];  cz = e[9];
      end
      MODE_CYL: begin
        ay = '0;    by = '0;    cy7 = '0;    cz = e[9];
      end
      MODE_CONE: begin
        ay = -e[1]; by = -e[4]; cy7 = '0;    cz = e[7];
      end
      default: begin
        ay = e[1];  by = e[4];  cy7 = e[7];  cz = e[9];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= m1_v[MUL_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1 <= (m1_mode[MUL_LAT-1] == MODE_PLANE);
      qa1 <= e[0] + ay + e[2];
      qb1 <= e[3] + by + e[5];
      qc1 <= e[6] + e[8] + cy7 - cz;
    end
  end

  // discriminant products
  logic signed [HW-1:0] bb_p, ac_p;

  rpi_mul #(.AW(QW), .BW(QW)) u_bb (
    .clk (clk), .en (en), .a (qb1), .b (qb1), .p (bb_p)
  );

  rpi_mul #(.AW(QW), .BW(QW)) u_ac (
    .clk (clk), .en (en), .a (qa1), .b (qc1), .p (ac_p)
  );

  // plane threshold over the same three stages
  logic                    e1_v, e2_v, e3_v;
  logic                    e1_pl, e2_pl, e3_pl;
  logic signed [QW-1:0]    e1_qa, e2_qa, e3_qa, e1_qb, e2_qb, e3_qb;
  logic signed [QW-1:0]    e1_num, e1_den, e2_den;
  logic                    e1_z, e2_z, e3_pok;
  logic signed [QW+KW-1:0] pe, e2_n10k;

  assign pe = {{KW{e1_num[QW-1]}}, e1_num};

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
    end else if (en) begin
      e1_v <= v1;
      e2_v <= e1_v;
      e3_v <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_pl   <= pl1;
      e1_qa   <= qa1;
      e1_qb   <= qb1;
      e1_num  <= qa1[QW-1] ? qb1 : -qb1;
      e1_den  <= qa1[QW-1] ? -qa1 : qa1;
      e1_z    <= (qa1 == '0);
      e2_pl   <= e1_pl;
      e2_qa   <= e1_qa;
      e2_qb   <= e1_qb;
      e2_den  <= e1_den;
      e2_z    <= e1_z;
      // x 10000 = 8192 + 1024 + 512 + 256 + 16
      e2_n10k <= (pe <<< 13) + (pe <<< 10) + (pe <<< 9) + (pe <<< 8) + (pe <<< 4);
      e3_pl   <= e2_pl;
      e3_qa   <= e2_qa;
      e3_qb   <= e2_qb;
      e3_pok  <= !e2_z && (e2_n10k >= $signed({{KW{1'b0}}, e2_den}));
    end
  end

  // stage 3: h = b*b - a*c
  logic                 v3, pl3, pok3, aok3;
  logic signed [HW-1:0] h3;
  logic signed [QW-1:0] qa3, qb3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= e3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl3  <= e3_pl;
      pok3 <= e3_pok;
      aok3 <= (e3_qa != '0);
      qa3  <= e3_qa;
      qb3  <= e3_qb;
      h3   <= bb_p - ac_p;
    end
  end

  // stage 4: hit decision, then square root, one root bit per stage
  logic                 hok;
  logic                 ok4;
  logic                 sq_v    [RW+1];
  logic                 sq_ok   [RW+1];
  logic                 sq_pl   [RW+1];
  logic signed [QW-1:0] sq_qa   [RW+1];
  logic signed [QW-1:0] sq_qb   [RW+1];
  logic [HW-1:0]        sq_x    [RW+1];
  logic [RW+1:0]        sq_rem  [RW+1];
  logic [RW-1:0]        sq_root [RW+1];

  assign hok = aok3 && !h3[HW-1] && ({{(TW-HW){1'b0}}, h3} >= HMIN);
  assign ok4 = pl3 ? pok3 : hok;

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ok[0]   <= ok4;
      sq_pl[0]   <= pl3;
      sq_qa[0]   <= qa3;
      sq_qb[0]   <= qb3;
      sq_x[0]    <= (ok4 && !pl3) ? $unsigned(h3) : '0;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RW+1:0] remx, trial;

    assign remx  = {sq_rem[j][RW-1:0], sq_x[j][HW-1 -: 2]};
    assign trial = {sq_root[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_ok[j+1] <= sq_ok[j];
        sq_pl[j+1] <= sq_pl[j];
        sq_qa[j+1] <= sq_qa[j];
        sq_qb[j+1] <= sq_qb[j];
        sq_x[j+1]  <= sq_x[j] << 2;
        if (remx >= trial) begin
          sq_rem[j+1]  <= remx - trial;
          sq_root[j+1] <= {sq_root[j][RW-2:0], 1'b1};
        end else begin
          sq_rem[j+1]  <= remx;
          sq_root[j+1] <= {sq_root[j][RW-2:0], 1'b0};
        end
      end
    end
  end

  // stage 5a: signed numerator and denominator
  logic signed [NW-1:0] qa_n, qb_n, rt_n;
  logic                 v5, ok5;
  logic signed [NW-1:0] n5, d5;

  assign qa_n = NW'(sq_qa[RW]);
  assign qb_n = NW'(sq_qb[RW]);
  assign rt_n = $signed(NW'(sq_root[RW]));

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= sq_v[RW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5 <= sq_ok[RW];
      if (sq_pl[RW]) begin
        n5 <= qa_n[NW-1] ? qb_n : -qb_n;
        d5 <= qa_n[NW-1] ? -qa_n : qa_n;
      end else begin
        n5 <= -qb_n - rt_n;
        d5 <= qa_n;
      end
    end
  end

  // stage 5b: magnitudes and quotient sign
  logic          v6, ok6, neg6;
  logic [MW-1:0] nm6;
  logic [QW-1:0] dm6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok6  <= ok5;
      neg6 <= n5[NW-1] ^ d5[NW-1];
      nm6  <= MW'(n5[NW-1] ? -n5 : n5);
      dm6  <= QW'(d5[NW-1] ? -d5 : d5);
    end
  end

  // stage 5c: overflow check, then one quotient bit per stage
  logic [XW-1:0] xn6, xd6;
  logic          dv_v   [W+1];
  logic          dv_ok  [W+1];
  logic          dv_neg [W+1];
  logic          dv_ovf [W+1];
  logic [XW-1:0] dv_x   [W+1];
  logic [QW-1:0] dv_d   [W+1];
  logic [W-1:0]  dv_q   [W+1];

  assign xn6 = XW'(nm6) << F;
  assign xd6 = XW'(dm6) << W;

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ok[0]  <= ok6;
      dv_neg[0] <= neg6;
      dv_ovf[0] <= (xn6 >= xd6);
      dv_x[0]   <= xn6;
      dv_d[0]   <= dm6;
      dv_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int BI = W - 1 - j;
    logic [XW-1:0] dsh;
    logic          ge;

    assign dsh = XW'(dv_d[j]) << BI;
    assign ge  = (dv_x[j] >= dsh);

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ok[j+1]  <= dv_ok[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_ovf[j+1] <= dv_ovf[j];
        dv_d[j+1]   <= dv_d[j];
        dv_x[j+1]   <= ge ? dv_x[j] - dsh : dv_x[j];
        dv_q[j+1]   <= dv_q[j] | (W'(ge) << BI);
      end
    end
  end

  // final: sign and saturation
  logic                fin_v, fin_hit;
  logic signed [W-1:0] fin_dist;
  logic                sat;
  logic [W-1:0]        qm;
  rsp_t                fin;

  assign qm  = dv_q[W];
  assign sat = dv_ovf[W] || qm[W-1];

  always_ff @(posedge clk) begin
    if (rst) fin_v <= 1'b0;
    else if (en) fin_v <= dv_v[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_hit <= dv_ok[W];
      if (!dv_ok[W]) fin_dist <= '0;
      else if (sat) fin_dist <= dv_neg[W] ? DIST_MIN : DIST_MAX;
      else fin_dist <= dv_neg[W] ? -$signed(qm) : $signed(qm);
    end
  end

  assign fin.hit      = fin_hit;
  assign fin.distance = fin_dist;

  // output register with skid
  logic take;

  assign take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (take) begin
      rsp_valid <= skid_v || fin_v;
      skid_v    <= 1'b0;
    end else if (!skid_v && fin_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rsp <= skid_v ? skid : fin;
    else if (!skid_v) skid <= fin;
  end

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> rsp_valid)
    else $error("skid holds an item while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && !rsp_stall |=> rsp_valid && !skid_v)
    else $error("skid item not moved to output");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fin_v) && $stable(fin_dist) && $stable(fin_hit))
    else $error("pipeline moved while held");

endmodule
